// ===== src/tgd_pkg.sv =====
package tgd_pkg;

  // pipeline depths of the iterative units
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 32;

  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_CELL_SIZE  = 3'd1,
    REG_INV_CELL   = 3'd2,
    REG_Z_INV      = 3'd3,
    REG_LIMIT_X    = 3'd4,
    REG_LIMIT_Y    = 3'd5,
    REG_RING       = 3'd6,
    REG_THICKNESS  = 3'd7
  } reg_idx_t;

  // settings used by the folding front end
  typedef struct packed {
    logic        clamped;
    logic [30:0] cell_size;
    logic [30:0] inv_cell_size;
    logic [30:0] z_inv_scale;
    logic [9:0]  limit_x;
    logic [9:0]  limit_y;
  } fold_cfg_t;

  // point and running distance carried through the divider
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dist_in;
  } point_t;

  // values riding alongside the square roots
  typedef struct packed {
    logic signed [31:0] dist_in;
    logic [30:0]        q;
    logic [31:0]        aux;
  } side_t;

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX_W) return 32'sh7fffffff;
    else if (v < S32_MIN_W) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // magnitude of a 32-bit signed value
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== src/tgd_div.sv =====
module tgd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [30:0]     thickness,
  input  logic [30:0]     de,
  input  tgd_pkg::point_t in_pt,
  output logic            out_valid,
  output logic [30:0]     q,
  output tgd_pkg::point_t out_pt
);
  import tgd_pkg::*;

  logic [DIV_STEPS-1:0] vld_r;
  logic [31:0]          rem_r [DIV_STEPS];
  logic [31:0]          rem_nxt [DIV_STEPS];
  logic [31:0]          dvs_r [DIV_STEPS];
  logic [31:0]          dvs_nxt [DIV_STEPS];
  logic [30:0]          quo_r [DIV_STEPS];
  logic [30:0]          quo_nxt [DIV_STEPS];
  point_t               pt_r [DIV_STEPS];
  point_t               pt_nxt [DIV_STEPS];
  logic [30:0]          num_w;

  // low numerator bits, brought in one per stage
  assign num_w = {thickness[14:0], 16'd0};

  // one restoring step per stage, quotient msb first
  always_comb begin
    logic [31:0] src_rem;
    logic [31:0] src_dvs;
    logic [30:0] src_quo;
    logic [32:0] trial;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        src_rem   = {16'd0, thickness[30:15]};
        src_dvs   = {1'b0, de} + 32'h0001_0000;
        src_quo   = '0;
        pt_nxt[i] = in_pt;
      end else begin
        src_rem   = rem_r[i-1];
        src_dvs   = dvs_r[i-1];
        src_quo   = quo_r[i-1];
        pt_nxt[i] = pt_r[i-1];
      end
      trial = {src_rem, num_w[DIV_STEPS-1-i]};
      if (trial >= {1'b0, src_dvs}) begin
        rem_nxt[i] = 32'(trial - {1'b0, src_dvs});
        quo_nxt[i] = {src_quo[29:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[31:0];
        quo_nxt[i] = {src_quo[29:0], 1'b0};
      end
      dvs_nxt[i] = src_dvs;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_nxt;
      quo_r <= quo_nxt;
      pt_r  <= pt_nxt;
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign q         = quo_r[DIV_STEPS-1];
  assign out_pt    = pt_r[DIV_STEPS-1];

endmodule

// ===== src/tgd_isqrt.sv =====
module tgd_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    radicand,
  input  tgd_pkg::side_t in_side,
  output logic           out_valid,
  output logic [31:0]    root,
  output tgd_pkg::side_t out_side
);
  import tgd_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  logic [63:0]           val_r [SQRT_STEPS];
  logic [63:0]           val_nxt [SQRT_STEPS];
  logic [63:0]           res_r [SQRT_STEPS];
  logic [63:0]           res_nxt [SQRT_STEPS];
  side_t                 side_r [SQRT_STEPS];
  side_t                 side_nxt [SQRT_STEPS];

  // one digit of the root per stage
  always_comb begin
    logic [63:0] src_val;
    logic [63:0] src_res;
    logic [63:0] bit_w;
    logic [63:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        src_val     = radicand;
        src_res     = '0;
        side_nxt[k] = in_side;
      end else begin
        src_val     = val_r[k-1];
        src_res     = res_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      bit_w = 64'd1 << (62 - 2 * k);
      trial = src_res + bit_w;
      if (src_val >= trial) begin
        val_nxt[k] = src_val - trial;
        res_nxt[k] = (src_res >> 1) + bit_w;
      end else begin
        val_nxt[k] = src_val;
        res_nxt[k] = src_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r  <= val_nxt;
      res_r  <= res_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign root      = res_r[SQRT_STEPS-1][31:0];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

// ===== src/tgd_fold.sv =====
module tgd_fold (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tgd_pkg::fold_cfg_t cfg,
  input  logic               in_valid,
  input  tgd_pkg::point_t    in_pt,
  input  logic [30:0]        in_q,
  output logic               out_valid,
  output logic [63:0]        sum_sq,
  output tgd_pkg::side_t     out_side
);
  import tgd_pkg::*;

  localparam logic signed [63:0] HALF_Q32 = 64'sd2147483648;

  // rounded cell index, clamped to the limit when asked
  function automatic logic signed [31:0] cell_index(input logic signed [63:0] r,
                                                    input logic clamped,
                                                    input logic [9:0] lim);
    logic signed [63:0] n;
    logic signed [63:0] l;
    l = $signed({54'd0, lim});
    if (!clamped || !r[63]) n = (r + HALF_Q32) >>> 32;
    else n = -((-r + HALF_Q32) >>> 32);
    if (clamped) begin
      if (n > l) n = l;
      if (n < -l) n = -l;
    end
    return n[31:0];
  endfunction

  // folded offset magnitude
  function automatic logic [31:0] fold_mag(input logic signed [63:0] d,
                                           input logic clamped);
    logic signed [63:0] a;
    if (clamped) return abs32(sat32(d));
    a = d[63] ? -d : d;
    if (a > S32_MAX_W) return 32'h7fff_ffff;
    return a[31:0];
  endfunction

  logic [5:0] vld_r;

  // stage 1: products
  logic signed [63:0] zprod_r, rx_r, ry_r;
  logic signed [31:0] px1_r, py1_r;
  side_t              side1_r;
  // stage 2: indexes
  logic signed [31:0] nx_r, ny_r, px2_r, py2_r;
  side_t              side2_r;
  // stage 3: cell offsets
  logic signed [63:0] prodx_r, prody_r;
  logic signed [31:0] px3_r, py3_r;
  side_t              side3_r;
  // stage 4: magnitudes
  logic [31:0]        ax_r, ay_r;
  side_t              side4_r;
  // stage 5: squares
  logic [63:0]        sqx_r, sqy_r;
  side_t              side5_r;
  // stage 6: sum
  logic [63:0]        sum_r;
  side_t              side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zprod_r         <= in_pt.pos_z * $signed({1'b0, cfg.z_inv_scale});
      rx_r            <= in_pt.pos_x * $signed({1'b0, cfg.inv_cell_size});
      ry_r            <= in_pt.pos_y * $signed({1'b0, cfg.inv_cell_size});
      px1_r           <= in_pt.pos_x;
      py1_r           <= in_pt.pos_y;
      side1_r.dist_in <= in_pt.dist_in;
      side1_r.q       <= in_q;
      side1_r.aux     <= '0;

      nx_r            <= cell_index(rx_r, cfg.clamped, cfg.limit_x);
      ny_r            <= cell_index(ry_r, cfg.clamped, cfg.limit_y);
      px2_r           <= px1_r;
      py2_r           <= py1_r;
      side2_r.dist_in <= side1_r.dist_in;
      side2_r.q       <= side1_r.q;
      side2_r.aux     <= abs32(sat32(zprod_r >>> 16));

      prodx_r <= $signed({1'b0, cfg.cell_size}) * nx_r;
      prody_r <= $signed({1'b0, cfg.cell_size}) * ny_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      side3_r <= side2_r;

      ax_r    <= fold_mag(64'(px3_r) - prodx_r, cfg.clamped);
      ay_r    <= fold_mag(64'(py3_r) - prody_r, cfg.clamped);
      side4_r <= side3_r;

      sqx_r   <= {32'd0, ax_r} * {32'd0, ax_r};
      sqy_r   <= {32'd0, ay_r} * {32'd0, ay_r};
      side5_r <= side4_r;

      sum_r   <= sqx_r + sqy_r;
      side6_r <= side5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign sum_sq    = sum_r;
  assign out_side  = side6_r;

endmodule

// ===== src/torus_grid_distance_unit.sv =====
// torus grid distance unit
// input channel in_*: one point per transfer with its running distance and
// derivative; output channel out_*: the updated minimum distance, one result
// per input, in order.
// configuration: cfg_we writes cfg_wdata into register cfg_index on the clock
// edge; write only while no point is in flight.
// pipeline: 31 divider stages for the thickness term, 6 folding stages,
// two 32-stage square root pipelines, 3 profile stages and the output
// register lie between input transfer and output valid.
// throughput: one point per cycle unless stalled; every stage is a register
// set and the square roots and the division retire one bit per stage.
// stall: when the output is valid and out_tready is low the whole pipeline
// holds, in_tready drops and nothing is lost or repeated; an empty output
// register keeps the pipeline moving.
// reset: rst_n low clears all valid bits and loads the default settings
// (infinite grid, round profile, cell 2.0, radius 1.0).
module torus_grid_distance_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], dist_in[127:96], de_so_far[158:128]
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dist_out[31:0]
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);
  import tgd_pkg::*;

  logic [1:0]  mode_r;
  logic [30:0] cell_size_r, inv_cell_r, z_inv_r, ring_r, thick_r;
  logic [9:0]  limit_x_r, limit_y_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 2'd0;
      cell_size_r <= 31'd131072;
      inv_cell_r  <= 31'd32768;
      z_inv_r     <= 31'd65536;
      limit_x_r   <= 10'd3;
      limit_y_r   <= 10'd3;
      ring_r      <= 31'd65536;
      thick_r     <= 31'd328;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:      mode_r      <= cfg_wdata[1:0];
        REG_CELL_SIZE: cell_size_r <= cfg_wdata;
        REG_INV_CELL:  inv_cell_r  <= cfg_wdata;
        REG_Z_INV:     z_inv_r     <= cfg_wdata;
        REG_LIMIT_X:   limit_x_r   <= cfg_wdata[9:0];
        REG_LIMIT_Y:   limit_y_r   <= cfg_wdata[9:0];
        REG_RING:      ring_r      <= cfg_wdata;
        REG_THICKNESS: thick_r     <= cfg_wdata;
        default:       mode_r      <= mode_r;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result waits
  logic adv;
  logic out_tvalid_r;
  logic [31:0] out_tdata_r;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  point_t    in_pt;
  fold_cfg_t fcfg;
  assign in_pt.pos_x   = in_tdata[31:0];
  assign in_pt.pos_y   = in_tdata[63:32];
  assign in_pt.pos_z   = in_tdata[95:64];
  assign in_pt.dist_in = in_tdata[127:96];

  assign fcfg.clamped       = mode_r[0];
  assign fcfg.cell_size     = cell_size_r;
  assign fcfg.inv_cell_size = inv_cell_r;
  assign fcfg.z_inv_scale   = z_inv_r;
  assign fcfg.limit_x       = limit_x_r;
  assign fcfg.limit_y       = limit_y_r;

  // thickness term
  logic        div_vld;
  logic [30:0] div_q;
  point_t      div_pt;

  tgd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .thickness (thick_r),
    .de        (in_tdata[158:128]),
    .in_pt     (in_pt),
    .out_valid (div_vld),
    .q         (div_q),
    .out_pt    (div_pt)
  );

  // grid folding and radial sum of squares
  logic        fold_vld;
  logic [63:0] fold_sum;
  side_t       fold_side;

  tgd_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (fcfg),
    .in_valid  (div_vld),
    .in_pt     (div_pt),
    .in_q      (div_q),
    .out_valid (fold_vld),
    .sum_sq    (fold_sum),
    .out_side  (fold_side)
  );

  // radial distance
  logic        rad_vld;
  logic [31:0] rad_root;
  side_t       rad_side;

  tgd_isqrt u_rad_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fold_vld),
    .radicand  (fold_sum),
    .in_side   (fold_side),
    .out_valid (rad_vld),
    .root      (rad_root),
    .out_side  (rad_side)
  );

  // profile stages
  logic [2:0]  pv_r;
  logic [31:0] at_r, az_r;
  logic [63:0] sqt_r, sqz_r, prof_sum_r;
  side_t       ps1_r, ps2_r, ps3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (adv) begin
      pv_r <= {pv_r[1:0], rad_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] at_w;
    if (adv) begin
      at_w          = abs32(sat32($signed({32'd0, rad_root}) - $signed({33'd0, ring_r})));
      at_r          <= at_w;
      az_r          <= rad_side.aux;
      ps1_r.dist_in <= rad_side.dist_in;
      ps1_r.q       <= rad_side.q;
      ps1_r.aux     <= (at_w > rad_side.aux) ? at_w : rad_side.aux;

      sqt_r <= {32'd0, at_r} * {32'd0, at_r};
      sqz_r <= {32'd0, az_r} * {32'd0, az_r};
      ps2_r <= ps1_r;

      prof_sum_r <= sqt_r + sqz_r;
      ps3_r      <= ps2_r;
    end
  end

  // round profile distance
  logic        tor_vld;
  logic [31:0] tor_root;
  side_t       tor_side;

  tgd_isqrt u_tor_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (pv_r[2]),
    .radicand  (prof_sum_r),
    .in_side   (ps3_r),
    .out_valid (tor_vld),
    .root      (tor_root),
    .out_side  (tor_side)
  );

  // candidate and running minimum into the output register
  logic [31:0]        tor_w;
  logic signed [31:0] cand_w;
  assign tor_w  = mode_r[1] ? tor_side.aux : tor_root;
  assign cand_w = sat32($signed({32'd0, tor_w}) - $signed({33'd0, tor_side.q}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= tor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= (tor_side.dist_in < cand_w) ? tor_side.dist_in : cand_w;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== verif/torus_grid_distance_unit_tb.sv =====
`timescale 1ns / 1ps

module torus_grid_distance_unit_tb;
  import tgd_pkg::*;

  localparam longint CLIP_MAX = 64'sd2147483647;
  localparam longint CLIP_MIN = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 120;
  localparam int     STALL_LIMIT = 4000;
  localparam int     RAND_PER_PHASE = 100;
  localparam int     N_DIRECTED = 16;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [30:0]  cfg_wdata;

  torus_grid_distance_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow copy of the settings
  logic [1:0]  sh_mode;
  logic [30:0] sh_cell;
  logic [30:0] sh_inv_cell;
  logic [30:0] sh_z_inv;
  logic [9:0]  sh_lim_x;
  logic [9:0]  sh_lim_y;
  logic [30:0] sh_ring;
  logic [30:0] sh_thick;

  logic signed [31:0] dist_expect_q[$];
  int  mismatch_cnt;
  int  stall_cnt;
  bit  quiet;
  bit  row_has_dist;
  logic signed [31:0] row_dist;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] din;
    logic [30:0]        de;
    bit                 known;
    logic signed [31:0] exp_val;
  } point_row_t;

  point_row_t directed_rows [N_DIRECTED];

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > CLIP_MAX) return CLIP_MAX;
    if (v < CLIP_MIN) return CLIP_MIN;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // fold one coordinate into the cell grid
  function automatic longint fold_axis(longint v, bit clamped, longint lim);
    longint r;
    longint n;
    longint d;
    r = v * longint'(sh_inv_cell);
    if (!clamped) begin
      n = (r + 64'sd2147483648) >>> 32;
      d = v - longint'(sh_cell) * n;
      if (d < 0) d = -d;
      return (d > CLIP_MAX) ? CLIP_MAX : d;
    end
    if (r >= 0) n = (r + 64'sd2147483648) >>> 32;
    else n = -((-r + 64'sd2147483648) >>> 32);
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
    d = v - longint'(sh_cell) * n;
    return clip32(d);
  endfunction

  function automatic logic signed [31:0] torus_min_dist(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] din,
      logic [30:0] de);
    longint zs, fx, fy, t, tor, q, cand;
    longint unsigned ax, ay, at, az, thick_sh;
    zs = clip32((longint'(pz) * longint'(sh_z_inv)) >>> 16);
    fx = fold_axis(longint'(px), sh_mode[0], longint'(sh_lim_x));
    fy = fold_axis(longint'(py), sh_mode[0], longint'(sh_lim_y));
    ax = (fx < 0) ? -fx : fx;
    ay = (fy < 0) ? -fy : fy;
    t = clip32(longint'(root64(ax * ax + ay * ay)) - longint'(sh_ring));
    at = (t < 0) ? -t : t;
    az = (zs < 0) ? -zs : zs;
    if (!sh_mode[1]) tor = longint'(root64(at * at + az * az));
    else tor = longint'((at > az) ? at : az);
    thick_sh = longint'(sh_thick) << 16;
    q = longint'(thick_sh / (longint'(de) + 64'd65536));
    cand = clip32(tor - q);
    return (longint'(din) < cand) ? din : cand[31:0];
  endfunction

  // track settings, predict on input transfer, check on output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      sh_mode <= 2'd0;
      sh_cell <= 31'd131072;
      sh_inv_cell <= 31'd32768;
      sh_z_inv <= 31'd65536;
      sh_lim_x <= 10'd3;
      sh_lim_y <= 10'd3;
      sh_ring <= 31'd65536;
      sh_thick <= 31'd328;
      stall_cnt <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:      sh_mode <= cfg_wdata[1:0];
          REG_CELL_SIZE: sh_cell <= cfg_wdata;
          REG_INV_CELL:  sh_inv_cell <= cfg_wdata;
          REG_Z_INV:     sh_z_inv <= cfg_wdata;
          REG_LIMIT_X:   sh_lim_x <= cfg_wdata[9:0];
          REG_LIMIT_Y:   sh_lim_y <= cfg_wdata[9:0];
          REG_RING:      sh_ring <= cfg_wdata;
          REG_THICKNESS: sh_thick <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (row_has_dist) dist_expect_q.push_back(row_dist);
        else dist_expect_q.push_back(torus_min_dist(in_tdata[31:0], in_tdata[63:32],
            in_tdata[95:64], in_tdata[127:96], in_tdata[158:128]));
      end
      if (out_tvalid && out_tready) begin
        if (dist_expect_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("unexpected result transfer: dist_out=%0d", $signed(out_tdata));
        end else begin
          if (out_tdata !== dist_expect_q[0]) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display("dist_out mismatch: expected %0d actual %0d",
                       dist_expect_q[0], $signed(out_tdata));
          end
          void'(dist_expect_q.pop_front());
        end
      end
      // watchdog on cycles without any transfer
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else stall_cnt <= stall_cnt + 1;
    end
  end

  // receiver backpressure in short random bursts
  int rdy_hold;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
      rdy_hold <= 0;
    end else if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0) ? 1'b1 : ~out_tready;
      rdy_hold <= $urandom_range(0, 3);
    end
  end

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, logic signed [31:0] din, logic [30:0] de,
      bit known, logic signed [31:0] exp_val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, de, din, pz, py, px};
    row_has_dist <= known;
    row_dist <= exp_val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    row_has_dist <= 1'b0;
    @(posedge clk);
    while (dist_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write per cycle, the caller drops the enable after the last one
  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [1:0] m, logic [30:0] cs, logic [30:0] ics,
      logic [30:0] zi, logic [9:0] lx, logic [9:0] ly, logic [30:0] rr, logic [30:0] th);
    // unused upper bits of mode are set on purpose
    write_reg(REG_MODE, {29'h1fffffff, m});
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_INV_CELL, ics);
    write_reg(REG_Z_INV, zi);
    write_reg(REG_LIMIT_X, {21'h0a5a5, lx});
    write_reg(REG_LIMIT_Y, {21'h15a5a, ly});
    write_reg(REG_RING, rr);
    write_reg(REG_THICKNESS, th);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 9) < 7) return $signed($urandom) >>> $urandom_range(10, 22);
    return $urandom;
  endfunction

  task automatic random_points(int n);
    logic signed [31:0] din;
    logic [30:0] de;
    for (int i = 0; i < n; i++) begin
      din = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : $urandom;
      de = 31'($urandom >> $urandom_range(1, 28));
      send_point(rand_coord(), rand_coord(), rand_coord(), din, de, 1'b0, '0);
    end
  endtask

  initial begin
    // directed points under the reset settings
    directed_rows[0]  = '{0, 0, 0, 32'sh7fffffff, 0, 1, 65208};
    directed_rows[1]  = '{0, 0, 0, 32'sh80000000, 0, 1, 32'sh80000000};
    directed_rows[2]  = '{0, 0, 0, -5, 0, 1, -5};
    directed_rows[3]  = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 31'h7fffffff, 0, 0};
    directed_rows[4]  = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh7fffffff, 0, 0, 0};
    directed_rows[5]  = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 65536, 0, 0};
    directed_rows[6]  = '{65536, 0, 0, 32'sh7fffffff, 0, 0, 0};
    directed_rows[7]  = '{65536, 65536, 0, 32'sh7fffffff, 0, 0, 0};
    // exactly on a cell boundary, both signs
    directed_rows[8]  = '{65536 * 3, -65536 * 3, 0, 32'sh7fffffff, 0, 0, 0};
    directed_rows[9]  = '{-65536, 65536, 32768, 32'sh7fffffff, 0, 0, 0};
    directed_rows[10] = '{1 << 20, -(1 << 20), -(1 << 16), 32'sh7fffffff, 31'd1, 0, 0};
    directed_rows[11] = '{0, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0};
    directed_rows[12] = '{0, 0, 32'sh80000000, 32'sh7fffffff, 0, 0, 0};
    directed_rows[13] = '{12345, -54321, 99999, 32'sh7fffffff, 31'h55555555, 0, 0};
    directed_rows[14] = '{-1, -1, -1, -1, 31'h2aaaaaaa, 0, 0};
    directed_rows[15] = '{1, 1, 1, 0, 31'h7fffffff, 0, 0};

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_wdata <= '0;
    row_has_dist <= 1'b0;
    row_dist <= '0;
    mismatch_cnt = 0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                 directed_rows[i].din, directed_rows[i].de, directed_rows[i].known,
                 directed_rows[i].exp_val);
    random_points(RAND_PER_PHASE / 2);
    drain_pipeline();

    // clamped grid, one limit at each extreme
    apply_settings(2'd1, 31'd131072, 31'd32768, 31'd65536, 10'd0, 10'd1023,
                   31'd65536, 31'd328);
    random_points(RAND_PER_PHASE);
    drain_pipeline();

    // square profile with the smallest settings
    apply_settings(2'd2, 31'd1, 31'd1, 31'd1, 10'd1023, 10'd0, 31'd0, 31'd0);
    random_points(RAND_PER_PHASE);
    drain_pipeline();

    // everything but the limits at its largest, clamped square
    apply_settings(2'd3, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 10'd5, 10'd2,
                   31'h7fffffff, 31'h7fffffff);
    random_points(RAND_PER_PHASE);
    drain_pipeline();

    // consistent spacing of three, infinite round
    apply_settings(2'd0, 31'd196608, 31'd21845, 31'd32768, 10'd3, 10'd3,
                   31'd98304, 31'd6553600);
    random_points(RAND_PER_PHASE);
    drain_pipeline();

    // final stretch with no idling on either side
    apply_settings(2'd1, 31'd65536, 31'd65536, 31'd131072, 10'd2, 10'd4,
                   31'd32768, 31'd1000);
    quiet = 1'b1;
    random_points(RAND_PER_PHASE / 2);
    drain_pipeline();

    if (mismatch_cnt == 0 && dist_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tgd_pkg.sv
src/tgd_div.sv
src/tgd_isqrt.sv
src/tgd_fold.sv
src/torus_grid_distance_unit.sv
verif/torus_grid_distance_unit_tb.sv
